// ===== design/pwmpc_pkg.sv =====
// Types, constants and divider table helpers shared by the PWM prescale calculator.
`timescale 1ns / 1ps
`default_nettype none
package pwmpc_pkg;

    localparam int FREQ_W      = 27;
    localparam int DUTY_W      = 7;
    localparam int WORD_W      = 16;
    localparam int ACT_W       = 5;
    localparam int DIV_ENTRIES = 36;
    localparam int IDX_W       = 6;
    localparam int TOT_W       = 11;
    localparam int LIM_W       = 27;
    localparam int DVD_W       = 27;
    localparam int DVS_W       = DVD_W + TOT_W;
    localparam int PROD_W      = WORD_W + DUTY_W;

    localparam logic [WORD_W-1:0] TB_BASE    = 16'h0030;
    localparam int                HSDIV_POS  = 7;
    localparam int                CLKDIV_POS = 10;

    localparam logic [ACT_W-1:0] ACT_NONE        = 5'h00;
    localparam logic [ACT_W-1:0] ACT_ZERO_CLEAR  = 5'h01;
    localparam logic [ACT_W-1:0] ACT_ZERO_SET    = 5'h02;
    localparam logic [ACT_W-1:0] ACT_CMPUP_CLEAR = 5'h10;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
    localparam logic [DUTY_W-1:0] DUTY_ZERO = 7'd0;
    localparam logic [DVS_W-1:0]  PCT_DIV   = 38'd100;

    typedef enum logic [1:0] {
        CMD_INIT = 2'd0,
        CMD_FREQ = 2'd1,
        CMD_DUTY = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_RAW_WAIT,
        ST_SEL_WAIT,
        ST_PRD,
        ST_PRD_WAIT,
        ST_DUTY,
        ST_DCMP,
        ST_DCMP_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic              channel;
        logic [FREQ_W-1:0] freq_hz;
        logic [DUTY_W-1:0] duty_percent;
    } t_in_item;

    typedef struct packed {
        logic              out_channel;
        logic [WORD_W-1:0] period_word;
        logic [WORD_W-1:0] control_word;
        logic [WORD_W-1:0] compare_a;
        logic [ACT_W-1:0]  action_word;
        logic              counter_clear;
        logic              ignored;
    } t_res_item;

    function automatic logic [2:0] div_clk(input logic [IDX_W-1:0] idx);
        logic [3:0] grp;
        grp = idx[5:2] - 4'd1;
        if (idx < 6'd8) begin
            return 3'd0;
        end
        return grp[2:0];
    endfunction

    function automatic logic [2:0] div_hs(input logic [IDX_W-1:0] idx);
        if (idx < 6'd8) begin
            return idx[2:0];
        end
        return {1'b1, idx[1:0]};
    endfunction

    function automatic logic [TOT_W-1:0] div_total(input logic [IDX_W-1:0] idx);
        logic [2:0]       hs;
        logic [TOT_W-1:0] base;
        hs = div_hs(idx);
        if (hs == 3'd0) begin
            base = 11'd1;
        end else begin
            base = {7'd0, hs, 1'b0};
        end
        return base << div_clk(idx);
    endfunction

endpackage
`default_nettype wire

// ===== design/pwmpc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pwmpc_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [pwmpc_pkg::DVD_W-1:0] i_dividend,
    input  wire logic [pwmpc_pkg::DVS_W-1:0] i_divisor,
    output logic                            o_done,
    output logic [pwmpc_pkg::DVD_W-1:0]     o_quot
);
    import pwmpc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;

    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        if (!diff[DVS_W]) begin
            n_rem = diff[DVS_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], 1'b1};
        end else begin
            n_rem = trial[DVS_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(DVD_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule
`default_nettype wire

// ===== design/pwmpc_sel.sv =====
// Prescaler table search, one entry per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pwmpc_sel #(
    parameter int PERIOD_MAX = 65535
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [pwmpc_pkg::DVD_W-1:0] i_raw,
    output logic                             o_done,
    output logic [pwmpc_pkg::IDX_W-1:0]      o_idx
);
    import pwmpc_pkg::*;

    logic [DVD_W-1:0] r_raw;
    logic [IDX_W-1:0] r_idx;
    logic             r_run;
    logic             r_done;
    logic [LIM_W-1:0] lim;
    logic             hit;

    always_comb begin
        lim = LIM_W'(div_total(r_idx)) * LIM_W'(PERIOD_MAX);
        hit = (LIM_W'(r_raw) <= lim) || (r_idx == IDX_W'(DIV_ENTRIES - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_idx <= '0;
            end else if (r_run) begin
                if (hit) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_raw <= i_raw;
        end
    end

    assign o_done = r_done;
    assign o_idx  = r_idx;
endmodule
`default_nettype wire

// ===== design/pwm_prescale_period_duty_calc.sv =====
// Top level: per-channel PWM prescaler, period and duty register calculator.
// Init, refused or unused requests go straight to the result; set duty may run a duty
//   division; set frequency runs up to two serial divisions, a table search and a
//   duty division.
// Throughput: one item at a time; busy stays high until the result strobe.
// Reset: synchronous, active low; all channel registers and duties clear to zero.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none
module pwm_prescale_period_duty_calc #(
    parameter int NUM_CHANNELS = 2,
    parameter int SYS_CLOCK_HZ = 100000000,
    parameter int PERIOD_MAX   = 65535
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire pwmpc_pkg::t_in_item  i_item,
    output logic                      busy,
    output logic                      o_valid,
    output pwmpc_pkg::t_res_item      o_res
);
    import pwmpc_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [DVD_W-1:0]  SYS_CLK = DVD_W'(SYS_CLOCK_HZ);
    localparam logic [DVD_W-1:0]  PRD_MAX = DVD_W'(PERIOD_MAX);

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic              r_ch, n_ch;
    logic [FREQ_W-1:0] r_freq, n_freq;
    logic [DUTY_W-1:0] r_duty, n_duty;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [DVS_W-1:0]  r_dvs, n_dvs;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic              r_cleared, n_cleared;
    logic              r_ign, n_ign;
    logic              r_oor, n_oor;
    logic              r_valid, n_valid;
    t_res_item         r_res, n_res;

    logic [WORD_W-1:0] r_prd_st [NUM_CHANNELS];
    logic [WORD_W-1:0] r_ctl_st [NUM_CHANNELS];
    logic [WORD_W-1:0] r_cmp_st [NUM_CHANNELS];
    logic [ACT_W-1:0]  r_act_st [NUM_CHANNELS];
    logic [DUTY_W-1:0] r_dty_st [NUM_CHANNELS];

    logic              w_prd_we, w_ctl_we, w_cmp_we, w_act_we, w_dty_we;
    logic [WORD_W-1:0] w_prd, w_ctl, w_cmp;
    logic [ACT_W-1:0]  w_act;
    logic [DUTY_W-1:0] w_dty;
    logic [CH_W-1:0]   ch_idx;

    logic              div_start;
    logic [DVD_W-1:0]  div_dvd;
    logic [DVS_W-1:0]  div_dvs;
    logic              div_done;
    logic [DVD_W-1:0]  div_quot;
    logic              sel_start;
    logic              sel_done;
    logic [IDX_W-1:0]  sel_idx;

    assign ch_idx = CH_W'(r_ch);

    pwmpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    pwmpc_sel #(
        .PERIOD_MAX (PERIOD_MAX)
    ) u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sel_start),
        .i_raw   (div_quot),
        .o_done  (sel_done),
        .o_idx   (sel_idx)
    );

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_ch      = r_ch;
        n_freq    = r_freq;
        n_duty    = r_duty;
        n_idx     = r_idx;
        n_dvs     = r_dvs;
        n_prod    = r_prod;
        n_cleared = r_cleared;
        n_ign     = r_ign;
        n_oor     = r_oor;
        n_valid   = 1'b0;
        n_res     = r_res;
        div_start = 1'b0;
        div_dvd   = SYS_CLK;
        div_dvs   = DVS_W'(r_freq);
        sel_start = 1'b0;
        w_prd_we  = 1'b0;
        w_ctl_we  = 1'b0;
        w_cmp_we  = 1'b0;
        w_act_we  = 1'b0;
        w_dty_we  = 1'b0;
        w_prd     = '0;
        w_ctl     = '0;
        w_cmp     = '0;
        w_act     = ACT_NONE;
        w_dty     = r_duty;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_cmd     = i_item.cmd;
                    n_ch      = i_item.channel;
                    n_freq    = i_item.freq_hz;
                    n_duty    = i_item.duty_percent;
                    n_cleared = 1'b0;
                    n_ign     = 1'b0;
                    n_oor     = (int'(i_item.channel) >= NUM_CHANNELS);
                    n_state   = ST_DISP;
                end
            end
            ST_DISP: begin
                if (r_oor) begin
                    n_state = ST_DONE;
                end else begin
                    unique case (r_cmd)
                        CMD_INIT: begin
                            w_prd_we  = 1'b1;
                            w_ctl_we  = 1'b1;
                            w_cmp_we  = 1'b1;
                            w_act_we  = 1'b1;
                            n_cleared = 1'b1;
                            n_state   = ST_DONE;
                        end
                        CMD_FREQ: begin
                            n_duty = r_dty_st[ch_idx];
                            if (DVD_W'(r_freq) > SYS_CLK) begin
                                n_ign   = 1'b1;
                                n_state = ST_DONE;
                            end else if (r_freq == '0) begin
                                n_cleared = 1'b1;
                                w_prd_we  = 1'b1;
                                w_ctl_we  = 1'b1;
                                w_ctl     = TB_BASE;
                                n_state   = ST_DUTY;
                            end else begin
                                n_cleared = 1'b1;
                                div_start = 1'b1;
                                n_state   = ST_RAW_WAIT;
                            end
                        end
                        CMD_DUTY: begin
                            n_state = ST_DUTY;
                        end
                        CMD_NONE: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RAW_WAIT: begin
                if (div_done) begin
                    sel_start = 1'b1;
                    n_state   = ST_SEL_WAIT;
                end
            end
            ST_SEL_WAIT: begin
                if (sel_done) begin
                    n_idx   = sel_idx;
                    n_dvs   = DVS_W'(div_total(sel_idx)) * DVS_W'(r_freq);
                    n_state = ST_PRD;
                end
            end
            ST_PRD: begin
                div_start = 1'b1;
                div_dvs   = r_dvs;
                n_state   = ST_PRD_WAIT;
            end
            ST_PRD_WAIT: begin
                div_dvs = r_dvs;
                if (div_done) begin
                    w_prd_we = 1'b1;
                    w_ctl_we = 1'b1;
                    if (div_quot > PRD_MAX) begin
                        w_prd = PRD_MAX[WORD_W-1:0];
                    end else begin
                        w_prd = div_quot[WORD_W-1:0];
                    end
                    w_ctl = TB_BASE
                          | (WORD_W'(div_hs(r_idx)) << HSDIV_POS)
                          | (WORD_W'(div_clk(r_idx)) << CLKDIV_POS);
                    n_state = ST_DUTY;
                end
            end
            ST_DUTY: begin
                w_dty_we = 1'b1;
                w_cmp_we = 1'b1;
                w_act_we = 1'b1;
                priority if (r_duty >= DUTY_FULL) begin
                    w_dty   = DUTY_FULL;
                    w_act   = ACT_ZERO_SET;
                    n_state = ST_DONE;
                end else if (r_duty == DUTY_ZERO) begin
                    w_act   = ACT_ZERO_CLEAR;
                    n_state = ST_DONE;
                end else begin
                    w_cmp_we = 1'b0;
                    w_act_we = 1'b0;
                    n_prod   = PROD_W'(r_prd_st[ch_idx]) * PROD_W'(r_duty);
                    n_state  = ST_DCMP;
                end
            end
            ST_DCMP: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(r_prod);
                div_dvs   = PCT_DIV;
                n_state   = ST_DCMP_WAIT;
            end
            ST_DCMP_WAIT: begin
                if (div_done) begin
                    w_cmp_we = 1'b1;
                    w_act_we = 1'b1;
                    w_cmp    = div_quot[WORD_W-1:0];
                    w_act    = ACT_ZERO_SET | ACT_CMPUP_CLEAR;
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                n_valid             = 1'b1;
                n_res.out_channel   = r_ch;
                if (r_oor) begin
                    n_res.period_word   = '0;
                    n_res.control_word  = '0;
                    n_res.compare_a     = '0;
                    n_res.action_word   = ACT_NONE;
                end else begin
                    n_res.period_word   = r_prd_st[ch_idx];
                    n_res.control_word  = r_ctl_st[ch_idx];
                    n_res.compare_a     = r_cmp_st[ch_idx];
                    n_res.action_word   = r_act_st[ch_idx];
                end
                n_res.counter_clear = r_cleared;
                n_res.ignored       = r_ign;
                n_state             = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= 1'b0;
            r_cleared <= 1'b0;
            r_ign     <= 1'b0;
            r_oor     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_cleared <= n_cleared;
            r_ign     <= n_ign;
            r_oor     <= n_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_ch   <= n_ch;
        r_freq <= n_freq;
        r_duty <= n_duty;
        r_idx  <= n_idx;
        r_dvs  <= n_dvs;
        r_prod <= n_prod;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_prd_st[i] <= '0;
                r_ctl_st[i] <= '0;
                r_cmp_st[i] <= '0;
                r_act_st[i] <= '0;
                r_dty_st[i] <= '0;
            end
        end else begin
            if (w_prd_we) begin
                r_prd_st[ch_idx] <= w_prd;
            end
            if (w_ctl_we) begin
                r_ctl_st[ch_idx] <= w_ctl;
            end
            if (w_cmp_we) begin
                r_cmp_st[ch_idx] <= w_cmp;
            end
            if (w_act_we) begin
                r_act_st[ch_idx] <= w_act;
            end
            if (w_dty_we) begin
                r_dty_st[ch_idx] <= w_dty;
            end
        end
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule
`default_nettype wire

// ===== dv/pwm_prescale_period_duty_calc_test.sv =====
// Self-checking testbench for the PWM prescaler, period and duty calculator.
`timescale 1ns / 1ps
module pwm_prescale_period_duty_calc_test;
    import pwmpc_pkg::*;

    localparam int          CHANNELS     = 2;
    localparam int unsigned SYS_HZ       = 100000000;
    localparam int unsigned PRD_MAX      = 65535;
    localparam int unsigned FREQ_TOP     = (1 << FREQ_W) - 1;
    localparam int          TABLE_LAST   = DIV_ENTRIES - 1;
    localparam int          RANDOM_ITEMS = 1250;
    localparam int          SETTLE       = 160;
    localparam int          RUN_LIMIT    = 1500000;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    wire logic busy;
    wire logic o_valid;
    t_res_item o_res;

    logic [WORD_W-1:0] period_q  [CHANNELS];
    logic [WORD_W-1:0] control_q [CHANNELS];
    logic [WORD_W-1:0] compare_q [CHANNELS];
    logic [ACT_W-1:0]  action_q  [CHANNELS];
    logic [DUTY_W-1:0] duty_q    [CHANNELS];

    t_in_item  pending_items [$];
    t_res_item expected_words [$];

    int errors       = 0;
    int total_items  = 0;
    int accepted     = 0;
    int results_seen = 0;
    int freq_count   = 0;
    int duty_count   = 0;
    int init_count   = 0;
    int idle_count   = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int cycle_count  = 0;

    pwm_prescale_period_duty_calc u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always #10 i_clk = ~i_clk;

    function automatic void prescale_entry(input int idx, output int unsigned total,
                                           output logic [2:0] clk_div,
                                           output logic [2:0] hs_div);
        if (idx < 8) begin
            clk_div = 3'd0;
            hs_div  = 3'(idx);
            total   = (idx == 0) ? 1 : 2 * idx;
        end else begin
            clk_div = 3'(idx / 4 - 1);
            hs_div  = 3'(4 + idx % 4);
            total   = (2 * (4 + idx % 4)) << (idx / 4 - 1);
        end
    endfunction

    task automatic apply_duty_words(input int ch, input logic [DUTY_W-1:0] duty);
        logic [DUTY_W-1:0] held;
        held = duty;
        if (duty >= DUTY_FULL) begin
            held          = DUTY_FULL;
            compare_q[ch] = '0;
            action_q[ch]  = ACT_ZERO_SET;
        end else if (duty == DUTY_ZERO) begin
            compare_q[ch] = '0;
            action_q[ch]  = ACT_ZERO_CLEAR;
        end else begin
            compare_q[ch] = WORD_W'((int'(period_q[ch]) * int'(duty)) / 100);
            action_q[ch]  = ACT_ZERO_SET | ACT_CMPUP_CLEAR;
        end
        duty_q[ch] = held;
    endtask

    task automatic apply_freq_words(input int ch, input int unsigned freq);
        int unsigned raw;
        int unsigned need;
        int unsigned total;
        int unsigned prd;
        int          idx;
        logic [2:0]  clk_div;
        logic [2:0]  hs_div;
        raw = (freq > 0) ? SYS_HZ / freq : 0;
        need = (raw + PRD_MAX - 1) / PRD_MAX;
        idx = 0;
        prescale_entry(idx, total, clk_div, hs_div);
        while (idx < TABLE_LAST && total < need) begin
            idx++;
            prescale_entry(idx, total, clk_div, hs_div);
        end
        prd = (freq > 0) ? SYS_HZ / total / freq : 0;
        if (prd > PRD_MAX) begin
            prd = PRD_MAX;
        end
        period_q[ch]  = WORD_W'(prd);
        control_q[ch] = TB_BASE | (WORD_W'(hs_div) << HSDIV_POS)
                        | (WORD_W'(clk_div) << CLKDIV_POS);
        apply_duty_words(ch, duty_q[ch]);
    endtask

    task automatic predict_words(input t_in_item it, output t_res_item res);
        int ch;
        ch = int'(it.channel);
        res = '0;
        res.out_channel = it.channel;
        case (it.cmd)
            CMD_INIT: begin
                period_q[ch]      = '0;
                control_q[ch]     = '0;
                compare_q[ch]     = '0;
                action_q[ch]      = ACT_NONE;
                res.counter_clear = 1'b1;
            end
            CMD_FREQ: begin
                if (32'(it.freq_hz) > SYS_HZ) begin
                    res.ignored = 1'b1;
                end else begin
                    apply_freq_words(ch, 32'(it.freq_hz));
                    res.counter_clear = 1'b1;
                end
            end
            CMD_DUTY: begin
                apply_duty_words(ch, it.duty_percent);
            end
            default: begin
            end
        endcase
        res.period_word  = period_q[ch];
        res.control_word = control_q[ch];
        res.compare_a    = compare_q[ch];
        res.action_word  = action_q[ch];
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic bit add_item(input t_cmd cmd, input int ch, input int unsigned freq,
                                    input int unsigned duty);
        t_in_item it;
        bit       useful;
        it.cmd          = cmd;
        it.channel      = ch[0];
        it.freq_hz      = freq[FREQ_W-1:0];
        it.duty_percent = duty[DUTY_W-1:0];
        pending_items.push_back(it);
        total_items++;
        useful = 1'b1;
        case (cmd)
            CMD_INIT: init_count++;
            CMD_DUTY: duty_count++;
            CMD_FREQ: begin
                if (32'(it.freq_hz) > SYS_HZ) begin
                    idle_count++;
                    useful = 1'b0;
                end else begin
                    freq_count++;
                end
            end
            default: begin
                idle_count++;
                useful = 1'b0;
            end
        endcase
        return useful;
    endfunction

    function automatic int unsigned pick_freq();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 0;
        if (r < 25) return $urandom_range(1, 2000);
        if (r < 65) return $urandom_range(1, SYS_HZ);
        if (r < 78) return $urandom_range(2000, 200000);
        if (r < 88) return SYS_HZ - $urandom_range(0, 50);
        return $urandom_range(SYS_HZ + 1, FREQ_TOP);
    endfunction

    function automatic int unsigned pick_duty();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return 0;
        if (r < 20) return 100;
        if (r < 30) return $urandom_range(101, 127);
        return $urandom_range(0, 127);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 75) return $urandom_range(1, 8);
        return $urandom_range(9, 160);
    endfunction

    always @(posedge i_clk) begin : drive_items
        t_res_item res;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_words(i_item, res);
                expected_words.push_back(res);
                accepted++;
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (pending_items.size() > 0) begin
                i_item <= pending_items.pop_front();
                start  <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = pick_gap();
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_res_item want;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                $display("%0t: result with nothing expected: expected none, actual %h",
                         $time, o_res);
                errors++;
            end else begin
                want = expected_words.pop_front();
                results_seen++;
                check_field("out_channel", 32'(want.out_channel), 32'(o_res.out_channel));
                check_field("period_word", 32'(want.period_word), 32'(o_res.period_word));
                check_field("control_word", 32'(want.control_word),
                            32'(o_res.control_word));
                check_field("compare_a", 32'(want.compare_a), 32'(o_res.compare_a));
                check_field("action_word", 32'(want.action_word), 32'(o_res.action_word));
                check_field("counter_clear", 32'(want.counter_clear),
                            32'(o_res.counter_clear));
                check_field("ignored", 32'(want.ignored), 32'(o_res.ignored));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("pwm_prescale_period_duty_calc regression: fail");
            $finish;
        end
    end

    initial begin : run_items
        int     useful;
        int     r;
        t_cmd   cmd;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            period_q[ch]  = '0;
            control_q[ch] = '0;
            compare_q[ch] = '0;
            action_q[ch]  = ACT_NONE;
            duty_q[ch]    = DUTY_ZERO;
        end

        void'(add_item(CMD_DUTY, 0, 0, 50));
        void'(add_item(CMD_FREQ, 0, 0, 0));
        void'(add_item(CMD_FREQ, 0, 1, 0));
        void'(add_item(CMD_FREQ, 0, SYS_HZ, 0));
        void'(add_item(CMD_FREQ, 0, SYS_HZ + 1, 0));
        void'(add_item(CMD_FREQ, 0, FREQ_TOP, 127));
        void'(add_item(CMD_DUTY, 0, 0, 0));
        void'(add_item(CMD_DUTY, 0, 0, 1));
        void'(add_item(CMD_DUTY, 0, 0, 99));
        void'(add_item(CMD_DUTY, 0, 0, 100));
        void'(add_item(CMD_DUTY, 0, 0, 127));
        void'(add_item(CMD_FREQ, 1, 1000, 0));
        void'(add_item(CMD_DUTY, 1, 0, 37));
        void'(add_item(CMD_FREQ, 1, 25000, 0));
        void'(add_item(CMD_FREQ, 1, 1526, 0));
        void'(add_item(CMD_FREQ, 1, 1525, 0));
        void'(add_item(CMD_NONE, 1, FREQ_TOP, 127));
        void'(add_item(CMD_INIT, 1, 0, 0));
        void'(add_item(CMD_DUTY, 1, 0, 100));
        void'(add_item(CMD_FREQ, 1, 3, 0));
        void'(add_item(CMD_INIT, 0, FREQ_TOP, 127));
        void'(add_item(CMD_NONE, 0, 0, 0));
        void'(add_item(CMD_FREQ, 0, 1 << (FREQ_W - 1), 0));
        void'(add_item(CMD_DUTY, 0, 0, 64));

        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 42) begin
                cmd = CMD_FREQ;
            end else if (r < 82) begin
                cmd = CMD_DUTY;
            end else if (r < 94) begin
                cmd = CMD_INIT;
            end else begin
                cmd = CMD_NONE;
            end
            if (add_item(cmd, $urandom_range(0, 1), pick_freq(), pick_duty())) begin
                useful++;
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted < total_items) @(posedge i_clk);
        while (expected_words.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Covered %0d items: %0d frequency, %0d duty, %0d init, %0d refused or unused.",
                 total_items, freq_count, duty_count, init_count, idle_count);
        $display("Checked %0d results over both channels with bursty start timing.",
                 results_seen);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("pwm_prescale_period_duty_calc regression: pass");
        end else begin
            $display("pwm_prescale_period_duty_calc regression: fail");
        end
        $finish;
    end

endmodule
